/* hdl/rlto_pkg.sv */
// Types, codes and timestamp arithmetic shared by the replay loop timestamp offset block.
package rlto_pkg;

    localparam int SEC_W = 32;
    localparam int NS_W  = 30;
    localparam int LOOP_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [NS_W-1:0] NS_MAX = NS_W'(999999999);
    localparam logic [NS_W:0]   NS_PER_SEC = (NS_W+1)'(1000000000);
    localparam logic [LOOP_W-1:0] LOOP_SAT = '1;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_TIMER = 2'd1,
        K_EOC   = 2'd2,
        K_OTHER = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_PASS     = 2'd0,
        ST_FINISH   = 2'd1,
        ST_RESTART  = 2'd2,
        ST_SEEK_ERR = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_LIMIT = 1'd0,
        CFG_RECALC_EN  = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]      kind;
        logic [SEC_W-1:0] stamp_sec;
        logic [NS_W-1:0]  stamp_ns;
        logic            seek_ok;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [SEC_W-1:0] out_sec;
        logic [NS_W-1:0]  out_ns;
    } t_out_item;

    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [NS_W-1:0]  ns;
    } t_ts;

    typedef struct packed {
        t_ts              offset;
        t_ts              begin_ts;
        t_ts              last;
        logic [LOOP_W-1:0] loops_done;
    } t_state;

    typedef struct packed {
        logic [LOOP_W-1:0] loop_limit;
        logic              recalc_enable;
    } t_cfg;

    // Both operands carry nanoseconds below one second, so one carry step is enough.
    function automatic t_ts ts_add(t_ts a, t_ts b);
        logic [NS_W:0] sum;
        t_ts r;
        sum = {1'b0, a.ns} + {1'b0, b.ns};
        r.sec = a.sec + b.sec;
        if (sum >= NS_PER_SEC) begin
            sum = sum - NS_PER_SEC;
            r.sec = r.sec + SEC_W'(1);
        end
        r.ns = sum[NS_W-1:0];
        return r;
    endfunction

    function automatic t_ts ts_sub(t_ts a, t_ts b);
        logic [NS_W:0] diff;
        t_ts r;
        r.sec = a.sec - b.sec;
        if (a.ns >= b.ns) begin
            diff = {1'b0, a.ns} - {1'b0, b.ns};
        end else begin
            diff = {1'b0, a.ns} + NS_PER_SEC - {1'b0, b.ns};
            r.sec = r.sec - SEC_W'(1);
        end
        r.ns = diff[NS_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/rlto_core.sv */
// Per-transaction next state and result computation for the timestamp offset block.
module rlto_core
    import rlto_pkg::*;
(
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_item o_result
);

    logic [NS_W-1:0]   sns;
    t_ts               stamp;
    t_ts               delta;
    logic [LOOP_W-1:0] loops_inc;

    always_comb begin
        sns = (i_item.stamp_ns > NS_MAX) ? NS_MAX : i_item.stamp_ns;
        stamp.sec = i_item.stamp_sec;
        stamp.ns  = sns;
        delta = ts_sub(i_state.last, i_state.begin_ts);
        loops_inc = (i_state.loops_done < LOOP_SAT) ? i_state.loops_done + LOOP_W'(1)
                                                     : i_state.loops_done;

        o_state = i_state;
        o_result.status  = ST_PASS;
        o_result.out_sec = i_item.stamp_sec;
        o_result.out_ns  = i_item.stamp_ns;

        case (i_item.kind) inside
            K_DATA, K_TIMER: begin
                if (i_cfg.recalc_enable) begin
                    o_state.last = stamp;
                    // Only the seconds word marks an empty begin stamp.
                    if (i_state.begin_ts.sec == '0) begin
                        o_state.begin_ts = stamp;
                    end
                    {o_result.out_sec, o_result.out_ns} = ts_add(stamp, i_state.offset);
                end
            end
            K_EOC: begin
                o_state.loops_done = loops_inc;
                if (i_cfg.loop_limit != '0 && loops_inc >= i_cfg.loop_limit) begin
                    o_result.status = ST_FINISH;
                end else begin
                    if (i_cfg.recalc_enable) begin
                        o_state.offset   = ts_add(i_state.offset, delta);
                        o_state.begin_ts = '0;
                    end
                    o_result.status = i_item.seek_ok ? ST_RESTART : ST_SEEK_ERR;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/replay_loop_timestamp_offset.sv */
// Top level of the replay loop timestamp offset block: handshake, state and config registers.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_in  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out (t_out_item)
//  cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle while o_in_ready is high. It sits in the input register
// after the accepting edge and moves into the result register once that register is empty
// or draining; its result is then on o_out until the receiver takes it.
// The loop state is updated as the item moves into the result register.
// Synchronous active-low reset clears the state and sets recalc_enable to 1.
// A stalled output holds its result; the input register keeps accepting while the
// result register can drain.
module replay_loop_timestamp_offset
    import rlto_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_state    r_state;
    t_cfg      r_cfg;

    t_state    n_state;
    t_out_item n_out;
    logic      advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    rlto_core u_core (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_limit    <= '0;
            r_cfg.recalc_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOOP_LIMIT: r_cfg.loop_limit    <= i_cfg_data[LOOP_W-1:0];
                CFG_RECALC_EN:  r_cfg.recalc_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // An empty result register must never block the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled while result register empty");

    // The loop count only moves upward between resets.
    a_loops_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_state.loops_done >= $past(r_state.loops_done))
        else $error("loop count decreased");

    // Stored nanosecond fields stay inside one second.
    a_ns_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_state.offset.ns} < NS_PER_SEC) && ({1'b0, r_state.last.ns} < NS_PER_SEC)
        && ({1'b0, r_state.begin_ts.ns} < NS_PER_SEC))
        else $error("stored nanoseconds out of range");

    // State changes only when a transaction moves into the result register.
    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a transaction");

endmodule

/* tb/sv/replay_loop_timestamp_offset_tb.sv */
// Self-checking testbench for the replay loop timestamp offset block.
module replay_loop_timestamp_offset_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlto_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [NS_W-1:0]  ns;
    } t_stamp;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow of the block: accumulated shift, loop bounds, loop count, registers.
    t_stamp            shift_acc  = '0;
    t_stamp            loop_start = '0;
    t_stamp            latest     = '0;
    logic [LOOP_W-1:0] loops_seen = '0;
    logic [LOOP_W-1:0] limit_reg  = '0;
    bit                shift_on   = 1'b1;

    t_out_item pending_results[$];
    t_dir_row  directed[$];
    t_out_item want_r;
    int        fault_count = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;
    int        gap_max     = 0;
    int        stall_mode  = 0;
    int        stall_left  = 0;

    replay_loop_timestamp_offset dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_stamp stamp_add(input t_stamp a, input t_stamp b);
        logic [NS_W:0] nsum;
        t_stamp        r;
        nsum  = {1'b0, a.ns} + {1'b0, b.ns};
        r.sec = a.sec + b.sec;
        if (nsum >= NS_PER_SEC) begin
            nsum  = nsum - NS_PER_SEC;
            r.sec = r.sec + 32'd1;
        end
        r.ns = nsum[NS_W-1:0];
        return r;
    endfunction

    function automatic t_stamp stamp_sub(input t_stamp a, input t_stamp b);
        logic [NS_W:0] ndiff;
        t_stamp        r;
        r.sec = a.sec - b.sec;
        if (a.ns >= b.ns) begin
            ndiff = {1'b0, a.ns} - {1'b0, b.ns};
        end else begin
            // Borrow one second from the seconds field.
            ndiff = {1'b0, a.ns} + NS_PER_SEC - {1'b0, b.ns};
            r.sec = r.sec - 32'd1;
        end
        r.ns = ndiff[NS_W-1:0];
        return r;
    endfunction

    // Advances the shadow state by one item and returns the result it should produce.
    function automatic t_out_item shifted_result(input t_in_item it);
        t_stamp    clipped;
        t_stamp    moved;
        t_out_item r;
        clipped.sec = it.stamp_sec;
        clipped.ns  = (it.stamp_ns > NS_MAX) ? NS_MAX : it.stamp_ns;
        r.status  = ST_PASS;
        r.out_sec = it.stamp_sec;
        r.out_ns  = it.stamp_ns;
        case (t_kind'(it.kind))
            K_DATA, K_TIMER: begin
                if (shift_on) begin
                    latest = clipped;
                    if (loop_start.sec == '0) begin
                        loop_start = clipped;
                    end
                    moved     = stamp_add(clipped, shift_acc);
                    r.out_sec = moved.sec;
                    r.out_ns  = moved.ns;
                end
            end
            K_EOC: begin
                if (loops_seen != LOOP_SAT) begin
                    loops_seen = loops_seen + 1'b1;
                end
                if (limit_reg != '0 && loops_seen >= limit_reg) begin
                    r.status = ST_FINISH;
                end else begin
                    if (shift_on) begin
                        shift_acc  = stamp_add(shift_acc, stamp_sub(latest, loop_start));
                        loop_start = '0;
                    end
                    r.status = it.seek_ok ? ST_RESTART : ST_SEEK_ERR;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.kind      = 2'($urandom_range(0, 3));
        it.stamp_sec = $urandom;
        it.stamp_ns  = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(0, NS_MAX));
        it.seek_ok   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic row(input t_kind k, input logic [SEC_W-1:0] sec, input logic [NS_W-1:0] ns,
                       input bit seek, input bit fixed, input t_status st,
                       input logic [SEC_W-1:0] wsec, input logic [NS_W-1:0] wns);
        t_dir_row r;
        r.item.kind      = k;
        r.item.stamp_sec = sec;
        r.item.stamp_ns  = ns;
        r.item.seek_ok   = seek;
        r.fixed          = fixed;
        r.want.status    = st;
        r.want.out_sec   = wsec;
        r.want.out_ns    = wns;
        directed.push_back(r);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer(input t_in_item it, input bit fixed, input t_out_item want);
        t_out_item pred;
        int        gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = shifted_result(it);
        pending_results.push_back(fixed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LOOP_LIMIT: limit_reg = val[LOOP_W-1:0];
            CFG_RECALC_EN:  shift_on  = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly whole loops of rising stamps closed by an end of capture, with some noise.
    task automatic play_loops(input int n_items);
        int       sent;
        int       pkts;
        t_stamp   cur;
        t_stamp   step;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                cur.sec = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
                cur.ns  = 30'($urandom_range(0, NS_MAX));
                pkts    = $urandom_range(1, 10);
                repeat (pkts) begin
                    it.kind      = $urandom_range(0, 1) ? K_TIMER : K_DATA;
                    it.stamp_sec = cur.sec;
                    it.stamp_ns  = ($urandom_range(0, 15) == 0) ? 30'($urandom) : cur.ns;
                    it.seek_ok   = 1'($urandom_range(0, 1));
                    offer(it, 1'b0, '0);
                    step.sec = 32'($urandom_range(0, 3));
                    step.ns  = 30'($urandom_range(0, NS_MAX));
                    cur      = stamp_add(cur, step);
                end
                it         = rand_item();
                it.kind    = K_EOC;
                it.seek_ok = ($urandom_range(0, 7) != 0);
                offer(it, 1'b0, '0);
                sent += pkts + 1;
            end else begin
                offer(rand_item(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // The receiver switches between steady, random and periodic stall patterns.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= (cycle_count % 3 == 0);
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result: status %0d sec %0d ns %0d",
                             o_out.status, o_out.out_sec, o_out.out_ns);
                end
            end else begin
                want_r = pending_results.pop_front();
                if (o_out.status !== want_r.status || o_out.out_sec !== want_r.out_sec ||
                    o_out.out_ns !== want_r.out_ns) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display({"mismatch: expected status %0d sec %0d ns %0d, ",
                                  "got status %0d sec %0d ns %0d"},
                                 want_r.status, want_r.out_sec, want_r.out_ns,
                                 o_out.status, o_out.out_sec, o_out.out_ns);
                    end
                end
            end
        end
    end

    initial begin
        t_in_item it;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LOOP_LIMIT;
        i_cfg_data = '0;

        // Rows after reset: no shift yet, so stamps pass through apart from clipping.
        row(K_OTHER, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b1, 1'b1, ST_PASS, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        row(K_DATA,  32'd0, NS_MAX, 1'b0, 1'b1, ST_PASS, 32'd0, NS_MAX);
        row(K_DATA,  32'd100, 30'h3FFF_FFFF, 1'b1, 1'b1, ST_PASS, 32'd100, NS_MAX);
        row(K_TIMER, 32'd105, 30'd250, 1'b0, 1'b1, ST_PASS, 32'd105, 30'd250);
        row(K_EOC,   32'd7, 30'h3FFF_FFFF, 1'b1, 1'b1, ST_RESTART, 32'd7, 30'h3FFF_FFFF);
        row(K_DATA,  32'd200, NS_MAX, 1'b0, 1'b0, ST_PASS, '0, '0);
        row(K_TIMER, 32'hFFFF_FFFF, 30'd5, 1'b1, 1'b0, ST_PASS, '0, '0);
        row(K_EOC,   32'd9, 30'd9, 1'b0, 1'b1, ST_SEEK_ERR, 32'd9, 30'd9);
        // A loop whose last stamp lies before its first one.
        row(K_DATA,  32'd50, 30'd10, 1'b0, 1'b0, ST_PASS, '0, '0);
        row(K_DATA,  32'd20, 30'd900, 1'b1, 1'b0, ST_PASS, '0, '0);
        row(K_EOC,   32'd0, 30'd0, 1'b1, 1'b0, ST_PASS, '0, '0);
        // Stamps with zero seconds do not pin the loop start.
        row(K_DATA,  32'd0, 30'd5, 1'b0, 1'b0, ST_PASS, '0, '0);
        row(K_TIMER, 32'd0, 30'h3FFF_FFFF, 1'b0, 1'b0, ST_PASS, '0, '0);
        row(K_DATA,  32'd30, 30'd1, 1'b1, 1'b0, ST_PASS, '0, '0);
        row(K_TIMER, 32'd31, NS_MAX, 1'b0, 1'b0, ST_PASS, '0, '0);
        row(K_EOC,   32'hFFFF_FFFF, NS_MAX, 1'b1, 1'b0, ST_PASS, '0, '0);
        row(K_OTHER, 32'd0, 30'd0, 1'b0, 1'b1, ST_PASS, 32'd0, 30'd0);
        row(K_DATA,  32'hFFFF_FFFF, NS_MAX, 1'b1, 1'b0, ST_PASS, '0, '0);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_max = 3;
        foreach (directed[i]) begin
            offer(directed[i].item, directed[i].fixed, directed[i].want);
        end

        write_reg(CFG_LOOP_LIMIT, 16'd0);
        gap_max = 6;
        play_loops(300);

        // Let a limit be reached partway through the phase.
        write_reg(CFG_LOOP_LIMIT, loops_seen + 16'd20);
        gap_max = 2;
        play_loops(250);

        write_reg(CFG_RECALC_EN, 16'd0);
        write_reg(CFG_LOOP_LIMIT, 16'd0);
        gap_max = 4;
        play_loops(200);

        write_reg(CFG_RECALC_EN, 16'd1);
        write_reg(CFG_LOOP_LIMIT, 16'hFFFF);
        gap_max = 0;
        play_loops(250);

        write_reg(CFG_LOOP_LIMIT, 16'd1);
        gap_max = 5;
        play_loops(150);

        // A few end-of-capture events back to back with no limit.
        write_reg(CFG_LOOP_LIMIT, 16'd0);
        gap_max = 0;
        repeat (4) begin
            it      = rand_item();
            it.kind = K_EOC;
            offer(it, 1'b0, '0);
        end
        write_reg(CFG_LOOP_LIMIT, 16'hFFFF);
        gap_max = 3;
        play_loops(40);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
